/* src/assert_macros.svh */
// assertion macros used by the checker in modexp_chk.sv
// no dependencies; expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHK_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/modexp_pkg.sv */
// shared constants for the 64-bit modular exponentiation core
// no dependencies
package modexp_pkg;

  localparam int W = 64;                          // width of every field
  localparam int CW = $clog2(W);                  // step counter width
  localparam logic [W-1:0] MOD_RESET = 64'hFFFF_FFFF_FFFF_FFC5;

endpackage

/* src/modular_exponentiation_64_core.sv */
// 64-bit modular exponentiation core, bit-serial square-and-multiply
// depends on modexp_pkg
//
//   channel  ports                         width  direction
//   in       in_valid/in_stall, base, exp  64+64  request in
//   out      out_valid/out_stall, power    64     request out
//   cfg      cfg_we, cfg_data (modulus)    64     write only
//
// a request reduces the base, then per exponent bit squares and, if the bit is set,
//   multiplies; each product runs the add-mod step, one multiplier bit per cycle
// a modulus below two gives 0, skipping the reduction and the products
// reset clears the control state and sets the modulus to 2^64 - 59
// a new request is taken while the previous result still waits in the output register;
//   a finished result waits in the final state while a full output register stalls
module modular_exponentiation_64_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [modexp_pkg::W-1:0] in_base,
  input  logic [modexp_pkg::W-1:0] in_exponent,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [modexp_pkg::W-1:0] out_power,
  input  logic                     cfg_we,
  input  logic [modexp_pkg::W-1:0] cfg_data
);
  import modexp_pkg::*;

  // controller states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request
  localparam logic [2:0] S_RED  = 3'd1;  // base mod modulus, one base bit a cycle
  localparam logic [2:0] S_SQR  = 3'd2;  // acc * acc, one multiplier bit a cycle
  localparam logic [2:0] S_MUL  = 3'd3;  // acc * base, one multiplier bit a cycle
  localparam logic [2:0] S_FIN  = 3'd4;  // result waits for the output register

  localparam logic [W-1:0] ONE  = W'(1);
  localparam logic [CW-1:0] LAST = CW'(W - 1);

  // (x + y) mod m for x, y < m
  function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;      // step within a reduction or a product
  logic [CW-1:0] ebit_r, ebit_nxt;    // exponent bits done
  logic [W-1:0]  mod_r;               // configured modulus
  logic [W-1:0]  base_r, base_nxt;    // raw base shifts out msb first, then reduced base
  logic [W-1:0]  exp_r, exp_nxt;      // exponent, msb first
  logic [W-1:0]  rem_r, rem_nxt;      // partial remainder of the base
  logic [W-1:0]  mac_r, mac_nxt;      // product accumulator, holds the result at the end
  logic [W-1:0]  ma_r, ma_nxt;        // multiplicand, doubled mod m each step
  logic [W-1:0]  mb_r, mb_nxt;        // multiplier, shifts out lsb first
  logic          out_valid_r, out_valid_nxt;
  logic [W-1:0]  out_power_r;

  logic [W:0]    rem_sh;
  logic [W-1:0]  rem_step;
  logic [W-1:0]  mac_step;
  logic [W-1:0]  ma_step;
  logic          accept;
  logic          out_load;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_load  = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_power = out_power_r;

  // restoring remainder step: shift in the next base bit, subtract if it fits
  always_comb begin
    rem_sh = {rem_r, base_r[W-1]};
    if (rem_sh >= {1'b0, mod_r}) begin
      rem_step = W'(rem_sh - {1'b0, mod_r});
    end else begin
      rem_step = rem_sh[W-1:0];
    end
  end

  // shift-and-add product step
  assign mac_step = mb_r[0] ? add_mod(mac_r, ma_r, mod_r) : mac_r;
  assign ma_step  = add_mod(ma_r, ma_r, mod_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ebit_nxt  = ebit_r;
    base_nxt  = base_r;
    exp_nxt   = exp_r;
    rem_nxt   = rem_r;
    mac_nxt   = mac_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    unique case (state_r) inside
      S_IDLE: begin
        if (accept) begin
          base_nxt = in_base;
          exp_nxt  = in_exponent;
          rem_nxt  = '0;
          cnt_nxt  = '0;
          ebit_nxt = '0;
          if (mod_r < W'(2)) begin
            // degenerate modulus: every residue is zero
            mac_nxt   = '0;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_RED;
          end
        end
      end
      S_RED: begin
        rem_nxt  = rem_step;
        base_nxt = {base_r[W-2:0], 1'b0};
        cnt_nxt  = cnt_r + CW'(1);
        if (cnt_r == LAST) begin
          // reduced base in place, first square of acc = 1
          base_nxt  = rem_step;
          mac_nxt   = '0;
          ma_nxt    = ONE;
          mb_nxt    = ONE;
          cnt_nxt   = '0;
          state_nxt = S_SQR;
        end
      end
      S_SQR, S_MUL: begin
        mac_nxt = mac_step;
        ma_nxt  = ma_step;
        mb_nxt  = {1'b0, mb_r[W-1:1]};
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == LAST) begin
          cnt_nxt = '0;
          if (state_r == S_SQR && exp_r[W-1]) begin
            // exponent bit set: multiply by the base
            mac_nxt   = '0;
            ma_nxt    = mac_step;
            mb_nxt    = base_r;
            state_nxt = S_MUL;
          end else begin
            exp_nxt  = {exp_r[W-2:0], 1'b0};
            ebit_nxt = ebit_r + CW'(1);
            if (ebit_r == LAST) begin
              state_nxt = S_FIN;
            end else begin
              mac_nxt   = '0;
              ma_nxt    = mac_step;
              mb_nxt    = mac_step;
              state_nxt = S_SQR;
            end
          end
        end
      end
      S_FIN: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register: freed when taken, refilled from the final state
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mod_r       <= MOD_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) mod_r <= cfg_data;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    ebit_r <= ebit_nxt;
    base_r <= base_nxt;
    exp_r  <= exp_nxt;
    rem_r  <= rem_nxt;
    mac_r  <= mac_nxt;
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    if (out_load) out_power_r <= mac_r;
  end

endmodule

/* src/modexp_chk.sv */
// port-level checker, bound to every instance of modular_exponentiation_64_core
// depends on modexp_pkg and assert_macros.svh
`include "assert_macros.svh"

module modexp_chk (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [modexp_pkg::W-1:0] out_power
);
  import modexp_pkg::*;

  // a stalled result stays offered and unchanged
  `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `CHK_NEXT(a_out_stable, out_valid && out_stall, $stable(out_power))
  // one request at a time: busy right after a request is taken
  `CHK_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)
  // a result only appears out of a busy core
  `CHK_SAME(a_result_from_busy, $rose(out_valid), $past(in_stall))

endmodule

bind modular_exponentiation_64_core modexp_chk u_modexp_chk (.*);
